/* rtl/utf16_decode_with_line_end_expand_top_defines.svh */
// Assertion macros shared by the UTF-16 decoder RTL.
// Expects clk and rst_n in the scope of every use; no other dependencies.
`ifndef UTF16_DECODE_WITH_LINE_END_EXPAND_TOP_DEFINES_SVH
`define UTF16_DECODE_WITH_LINE_END_EXPAND_TOP_DEFINES_SVH

// Condition holds at every clock edge outside reset
`define U16D_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle
`define U16D_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle
`define U16D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/u16d_pkg.sv */
// Shared types and constants for the UTF-16 decoder with line-end expansion.
// No dependencies; imported by every module of the block.
package u16d_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_LONE_LOW = 2'd1;
  localparam logic [ST_W-1:0] ST_HIGH_BAD = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_SECOND = 1'd1;

  localparam logic [UNIT_W-1:0] LINE_END_FIRST_RST  = 16'h000A;
  localparam logic [UNIT_W-1:0] LINE_END_SECOND_RST = 16'h0000;

  localparam logic [UNIT_W-1:0] UNIT_LINE_FEED  = 16'h000A;
  localparam logic [UNIT_W-1:0] UNIT_SURR_BASE  = 16'hD800;
  localparam logic [5:0]        HIGH_SURR_TAG   = 6'b110110;
  localparam logic [5:0]        LOW_SURR_TAG    = 6'b110111;
  localparam logic [CP_W-1:0]   SUPP_BASE       = 21'h010000;

  localparam int unsigned CMD_QUEUE_DEPTH = 4;

  // Classified work handed from the front to the back
  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [ST_W-1:0]   status;
    logic              two;
    logic [UNIT_W-1:0] second;
  } cmd_t;

endpackage

/* rtl/u16d_front.sv */
// Front end: configuration registers, surrogate tracking and unit classification.
// Depends on u16d_pkg; feeds u16d_fifo with one command per producing unit.
module u16d_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [u16d_pkg::UNIT_W-1:0]    in_code_unit,
  output logic                           in_full,
  input  logic                           cfg_we,
  input  logic [u16d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [u16d_pkg::UNIT_W-1:0]    cfg_data,
  input  logic                           cmd_full,
  output logic                           cmd_push,
  output u16d_pkg::cmd_t                 cmd
);
  import u16d_pkg::*;

  logic [UNIT_W-1:0] line_end_first_r;
  logic [UNIT_W-1:0] line_end_second_r;
  logic              high_pending_r, high_pending_nxt;
  logic [9:0]        high_bits_r, high_bits_nxt;

  logic accept;
  logic is_bmp, is_high, is_low, is_lf;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_end_first_r  <= LINE_END_FIRST_RST;
      line_end_second_r <= LINE_END_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_END_FIRST:  line_end_first_r  <= cfg_data;
        CFG_LINE_END_SECOND: line_end_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the incoming unit
  assign accept  = in_push && !cmd_full;
  assign is_bmp  = in_code_unit < UNIT_SURR_BASE;
  assign is_high = in_code_unit[15:10] == HIGH_SURR_TAG;
  assign is_low  = in_code_unit[15:10] == LOW_SURR_TAG;
  assign is_lf   = in_code_unit == UNIT_LINE_FEED;

  // Build the command for the back end
  always_comb begin
    cmd.code_point = '0;
    cmd.status     = ST_OK;
    cmd.two        = 1'b0;
    cmd.second     = line_end_second_r;
    if (is_bmp) begin
      if (is_lf) begin
        cmd.code_point = CP_W'(line_end_first_r);
        cmd.two        = line_end_second_r != '0;
      end else begin
        cmd.code_point = CP_W'(in_code_unit);
      end
    end else if (is_low) begin
      if (high_pending_r) begin
        cmd.code_point = SUPP_BASE + CP_W'({high_bits_r, in_code_unit[9:0]});
      end else begin
        cmd.status = ST_LONE_LOW;
      end
    end else if (!is_high) begin
      cmd.status = ST_HIGH_BAD;
    end
  end

  assign cmd_push = accept && !is_high;
  assign in_full  = cmd_full;

  // Track a held high surrogate; any other unit drops it
  always_comb begin
    high_pending_nxt = high_pending_r;
    high_bits_nxt    = high_bits_r;
    if (accept) begin
      high_pending_nxt = is_high;
      high_bits_nxt    = is_high ? in_code_unit[9:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pending_r <= 1'b0;
      high_bits_r    <= '0;
    end else begin
      high_pending_r <= high_pending_nxt;
      high_bits_r    <= high_bits_nxt;
    end
  end

endmodule

/* rtl/u16d_fifo.sv */
// Short command queue between the decoder front and back ends.
// Depends on u16d_pkg for the command type and the assertion macro header.
`include "utf16_decode_with_line_end_expand_top_defines.svh"
module u16d_fifo #(
  parameter int unsigned DEPTH = u16d_pkg::CMD_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u16d_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output u16d_pkg::cmd_t pop_data,
  output logic           empty
);
  import u16d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `U16D_ASSERT_ALWAYS(a_fifo_bound, count_r <= CNT_W'(DEPTH), "command queue overflow")
  `U16D_ASSERT_NEXT(a_fifo_grow, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count did not grow")
  `U16D_ASSERT_NEXT(a_fifo_shrink, do_pop && !do_push, count_r == $past(count_r) - 1'b1, "queue count did not shrink")

endmodule

/* rtl/u16d_back.sv */
// Back end: expands commands into result beats held in an output register.
// Depends on u16d_pkg for the command type and the assertion macro header.
`include "utf16_decode_with_line_end_expand_top_defines.svh"
module u16d_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  u16d_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [u16d_pkg::CP_W-1:0]   out_code_point,
  output logic [u16d_pkg::ST_W-1:0]   out_status,
  output logic                        out_last
);
  import u16d_pkg::*;

  logic            out_valid_r, out_valid_nxt;
  logic            phase_r, phase_nxt;
  logic [CP_W-1:0] out_code_point_r, out_code_point_nxt;
  logic [ST_W-1:0] out_status_r, out_status_nxt;
  logic            out_last_r, out_last_nxt;
  logic            load;

  // Refill the output register when it is free or being taken
  assign load = !out_valid_r || out_pop;

  always_comb begin
    out_valid_nxt      = out_valid_r;
    phase_nxt          = phase_r;
    out_code_point_nxt = out_code_point_r;
    out_status_nxt     = out_status_r;
    out_last_nxt       = out_last_r;
    cmd_pop            = 1'b0;
    if (load) begin
      priority if (phase_r) begin
        // Emit the second code point of a line ending
        out_valid_nxt      = 1'b1;
        out_code_point_nxt = CP_W'(cmd.second);
        out_status_nxt     = ST_OK;
        out_last_nxt       = 1'b1;
        phase_nxt          = 1'b0;
        cmd_pop            = 1'b1;
      end else if (cmd_valid) begin
        out_valid_nxt      = 1'b1;
        out_code_point_nxt = cmd.code_point;
        out_status_nxt     = cmd.status;
        out_last_nxt       = !cmd.two;
        phase_nxt          = cmd.two;
        cmd_pop            = !cmd.two;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    out_code_point_r <= out_code_point_nxt;
    out_status_r     <= out_status_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_code_point = out_code_point_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  `U16D_ASSERT_IMPLY(a_back_phase_cmd, phase_r, cmd_valid, "second beat without its command")
  `U16D_ASSERT_IMPLY(a_back_phase_out, phase_r, out_valid_r && !out_last_r, "first beat of pair not held")
  `U16D_ASSERT_IMPLY(a_back_pop_valid, cmd_pop, cmd_valid, "command popped from empty queue")

endmodule

/* rtl/utf16_decode_with_line_end_expand_top.sv */
// Top level of the UTF-16 decoder with line-end expansion.
// Depends on u16d_pkg, u16d_front, u16d_fifo and u16d_back.
//
// Usage:
//   Input queue port: drive in_code_unit and raise in_push; a beat is taken
//   at a clock edge with in_push high and in_full low.
//   Result queue port: while out_empty is low, out_code_point, out_status
//   and out_last show the oldest result; raise out_pop to take it.
//   Configuration: cfg_we with cfg_index 0 (line_end_first) or 1
//   (line_end_second) writes cfg_data; write only while the block is idle.
//   A unit that yields a result is queued, then loaded into the output register.
//   A high surrogate yields nothing and is held for the next unit.
//   Throughput: one unit per cycle while in_full is low; a two-code-point line
//   ending occupies the single result register of the back end for both of its
//   beats, so the command queue absorbs the extra beat; a long run of them fills
//   it and in_full then holds the input while the extra beats drain.
//   Reset: rst_n low at a clock edge clears the queues, the held surrogate and
//   restores line_end_first to 10 and line_end_second to 0.
//   Stall: with out_pop low the result holds; the command queue fills and then
//   in_full rises until the receiver takes results again.
module utf16_decode_with_line_end_expand_top #(
  parameter int unsigned QUEUE_DEPTH = u16d_pkg::CMD_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [u16d_pkg::UNIT_W-1:0]    in_code_unit,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [u16d_pkg::CP_W-1:0]      out_code_point,
  output logic [u16d_pkg::ST_W-1:0]      out_status,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [u16d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [u16d_pkg::UNIT_W-1:0]    cfg_data
);
  import u16d_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  // Classify input units
  u16d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_code_unit (in_code_unit),
    .in_full      (in_full),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd)
  );

  // Decouple front and back
  u16d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (push_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (head_cmd),
    .empty     (cmd_empty)
  );

  // Expand commands into result beats
  u16d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (!cmd_empty),
    .cmd            (head_cmd),
    .cmd_pop        (cmd_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule
